### rtl/core/plcl_pkg.sv
// Package for the pump level controller: command and event codes, reset values, field widths.
`default_nettype none
package plcl_pkg;

   // Timestamp width default
   localparam int TIME_WIDTH_DEF = 32;

   // Config register indexes
   localparam logic CSR_AUTO_LOCKOUT   = 1'b0;
   localparam logic CSR_MANUAL_LOCKOUT = 1'b1;
   localparam int   CSR_ADDR_W         = 1;
   localparam int   CSR_DATA_W         = 32;

   localparam logic [31:0] AUTO_LOCKOUT_RST   = 32'd3600000;
   localparam logic [31:0] MANUAL_LOCKOUT_RST = 32'd300000;

   // Command codes (func)
   localparam logic [2:0] FUNC_SENSE      = 3'd0;
   localparam logic [2:0] FUNC_MANUAL_ON  = 3'd1;
   localparam logic [2:0] FUNC_MANUAL_OFF = 3'd2;
   localparam logic [2:0] FUNC_AUTO_OFF   = 3'd3;
   localparam logic [2:0] FUNC_AUTO_ON    = 3'd4;
   localparam logic [2:0] FUNC_BL_OFF     = 3'd5;
   localparam logic [2:0] FUNC_BL_ON      = 3'd6;
   localparam logic [2:0] FUNC_RESTART    = 3'd7;

   // Automatic step events
   localparam logic [1:0] AEV_NONE  = 2'd0;
   localparam logic [1:0] AEV_START = 2'd1;
   localparam logic [1:0] AEV_FAULT = 2'd2;
   localparam logic [1:0] AEV_STOP  = 2'd3;

   // Command events
   localparam logic [2:0] CEV_NONE    = 3'd0;
   localparam logic [2:0] CEV_START   = 3'd1;
   localparam logic [2:0] CEV_REFUSED = 3'd2;
   localparam logic [2:0] CEV_STOP    = 3'd3;
   localparam logic [2:0] CEV_RESTART = 3'd4;

   // Run time in seconds: 23 bits, saturating
   localparam int          SEC_W     = 23;
   localparam logic [22:0] SEC_MAX   = 23'h7FFFFF;
   localparam int          MS_PER_SEC = 1000;
   // Smallest run length in ms that saturates the seconds field
   localparam logic [63:0] SAT_LIMIT = 64'((64'(SEC_MAX) + 64'd1) * 64'(MS_PER_SEC));

   // ms / 1000 = (ms >> 3) / 125, done as a multiply by ceil(2^37 / 125).
   // Exact for a 30-bit dividend.
   localparam int          DIVQ_W     = 30;
   localparam int          RECIP_SHIFT = 37;
   localparam int          RECIP_W    = 31;
   localparam logic [30:0] RECIP_125  = 31'd1099511628;
   localparam int          PROD_W     = DIVQ_W + RECIP_W;

   // Stream widths
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 40;

   // Result flags carried down the result pipeline
   typedef struct packed {
      logic       relay_on;
      logic       auto_enabled;
      logic       short_cycle_fault;
      logic       backlight_on;
      logic [1:0] auto_event;
      logic [2:0] command_event;
      logic       last_run_valid;
   } rsp_flags_type;

endpackage
`default_nettype wire

### rtl/core/pump_level_controller_lockout_core.sv
// Pump level controller with auto/manual lockout: state update and result pipeline.
//
// Usage:
//   req_* beats carry one sensor/command sample each: req_tuser is the command
//   code, req_tdata the timestamp and the two float switch states. Every request
//   beat yields exactly one rsp_* beat with the relay, mode, fault and backlight
//   state after that sample, the events it caused and the last run time in
//   seconds. csr_* writes the two lockout times; write only while idle.
//   Throughput: one beat per cycle while rsp_tready is high. The pump state
//   updates in the accept cycle; the result then passes a three-stage
//   pipeline (flags and stamps, run length with the saturation check, then
//   reciprocal multiply for the divide by 1000 with saturation).
//   Reset (synchronous, active high) clears the pump state to relay off, auto
//   mode on, no fault, and loads the default lockouts. A restart command does
//   the same to the pump state but keeps the lockout registers.
//   When rsp_tready is low the result pipeline holds; empty stages still take
//   new beats, so req_tready drops only once all three stages are full.
`default_nettype none
module pump_level_controller_lockout_core
   import plcl_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // now_ms[31:0], low_level_up, high_level_up
   input  wire logic [REQ_USER_W-1:0] req_tuser,  // func[2:0]
   // Response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // relay_on, auto_enabled, short_cycle_fault,
                                                  // backlight_on, auto_event[1:0],
                                                  // command_event[2:0],
                                                  // last_run_seconds[22:0], last_run_valid
   // Config write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

   // Request fields
   logic [2:0]            req_func;
   logic [TIME_WIDTH-1:0] now_t;
   logic [CW-1:0]         now_w;
   logic                  tank_low;
   logic                  tank_full;
   logic                  req_accept;

   assign req_func  = req_tuser;
   assign now_w     = CW'(req_tdata[31:0]);
   assign now_t     = now_w[TIME_WIDTH-1:0];
   assign tank_low  = ~req_tdata[32];
   assign tank_full = req_tdata[33];

   // Config registers
   logic [31:0] auto_lockout_ff;
   logic [31:0] manual_lockout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_lockout_ff   <= AUTO_LOCKOUT_RST;
         manual_lockout_ff <= MANUAL_LOCKOUT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_AUTO_LOCKOUT:   auto_lockout_ff   <= csr_wdata;
            CSR_MANUAL_LOCKOUT: manual_lockout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pump state
   logic [TIME_WIDTH-1:0] start_stamp_ff, start_stamp_in;
   logic [TIME_WIDTH-1:0] stop_stamp_ff,  stop_stamp_in;
   logic                  started_once_ff, started_once_in;
   logic                  stopped_once_ff, stopped_once_in;
   logic                  pump_running_ff, pump_running_in;
   logic                  run_from_auto_ff, run_from_auto_in;
   logic                  fault_ff, fault_in;
   logic                  auto_mode_ff, auto_mode_in;
   logic                  backlight_ff, backlight_in;
   logic [1:0]            aev;
   logic [2:0]            cev;
   logic                  run_valid;

   // Next state for one sample: auto step, high level stop, then command
   always_comb begin
      logic [TIME_WIDTH-1:0] since_stop;
      logic [TIME_WIDTH-1:0] since_start;
      logic [CW-1:0]         since_stop_w;
      logic [CW-1:0]         since_start_w;
      logic [CW-1:0]         auto_lo_w;
      logic [CW-1:0]         man_lo_w;

      start_stamp_in   = start_stamp_ff;
      stop_stamp_in    = stop_stamp_ff;
      started_once_in  = started_once_ff;
      stopped_once_in  = stopped_once_ff;
      pump_running_in  = pump_running_ff;
      run_from_auto_in = run_from_auto_ff;
      fault_in         = fault_ff;
      auto_mode_in     = auto_mode_ff;
      backlight_in     = backlight_ff;
      aev              = AEV_NONE;
      cev              = CEV_NONE;
      auto_lo_w        = CW'(auto_lockout_ff);
      man_lo_w         = CW'(manual_lockout_ff);

      // Auto step: low tank starts, or latches a short-cycle fault
      since_stop   = now_t - stop_stamp_ff;
      since_stop_w = CW'(since_stop);
      if (!fault_ff && tank_low) begin
         if ((!stopped_once_ff || since_stop_w >= auto_lo_w) && auto_mode_ff) begin
            pump_running_in  = 1'b1;
            run_from_auto_in = 1'b1;
            start_stamp_in   = now_t;
            started_once_in  = 1'b1;
            aev              = AEV_START;
         end else if (stopped_once_ff && since_stop_w <= auto_lo_w) begin
            fault_in = 1'b1;
            aev      = AEV_FAULT;
         end
      end

      // Full tank stops an auto run, or any run when no command is given, while auto mode is on
      if (tank_full && pump_running_in && auto_mode_ff &&
          (run_from_auto_in || req_func == FUNC_SENSE)) begin
         pump_running_in  = 1'b0;
         run_from_auto_in = 1'b0;
         stop_stamp_in    = now_t;
         stopped_once_in  = 1'b1;
         aev              = AEV_STOP;
      end

      // Command; manual lockout counts from the latest start, this sample's too
      since_start   = now_t - start_stamp_in;
      since_start_w = CW'(since_start);
      unique case (req_func)
         FUNC_SENSE: ;
         FUNC_MANUAL_ON: begin
            if (!started_once_in || since_start_w > man_lo_w) begin
               pump_running_in  = 1'b1;
               run_from_auto_in = 1'b0;
               start_stamp_in   = now_t;
               started_once_in  = 1'b1;
               cev              = CEV_START;
            end else if (!pump_running_in && since_start_w < man_lo_w) begin
               cev = CEV_REFUSED;
            end
         end
         FUNC_MANUAL_OFF: begin
            if (pump_running_in) begin
               pump_running_in  = 1'b0;
               run_from_auto_in = 1'b0;
               stop_stamp_in    = now_t;
               stopped_once_in  = 1'b1;
               cev              = CEV_STOP;
            end
         end
         FUNC_AUTO_OFF: auto_mode_in = 1'b0;
         FUNC_AUTO_ON:  auto_mode_in = 1'b1;
         FUNC_BL_OFF:   backlight_in = 1'b0;
         FUNC_BL_ON:    backlight_in = 1'b1;
         FUNC_RESTART: begin
            start_stamp_in   = '0;
            stop_stamp_in    = '0;
            started_once_in  = 1'b0;
            stopped_once_in  = 1'b0;
            pump_running_in  = 1'b0;
            run_from_auto_in = 1'b0;
            fault_in         = 1'b0;
            auto_mode_in     = 1'b1;
            backlight_in     = 1'b0;
            cev              = CEV_RESTART;
         end
      endcase

      run_valid = started_once_in && stopped_once_in && (stop_stamp_in > start_stamp_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_stamp_ff   <= '0;
         stop_stamp_ff    <= '0;
         started_once_ff  <= 1'b0;
         stopped_once_ff  <= 1'b0;
         pump_running_ff  <= 1'b0;
         run_from_auto_ff <= 1'b0;
         fault_ff         <= 1'b0;
         auto_mode_ff     <= 1'b1;
         backlight_ff     <= 1'b0;
      end else if (req_accept) begin
         start_stamp_ff   <= start_stamp_in;
         stop_stamp_ff    <= stop_stamp_in;
         started_once_ff  <= started_once_in;
         stopped_once_ff  <= stopped_once_in;
         pump_running_ff  <= pump_running_in;
         run_from_auto_ff <= run_from_auto_in;
         fault_ff         <= fault_in;
         auto_mode_ff     <= auto_mode_in;
         backlight_ff     <= backlight_in;
      end
   end

   // Result pipeline handshake: a stage loads when it is empty or moves on
   logic a_valid_ff, b_valid_ff, c_valid_ff;
   logic a_rdy, b_rdy, c_rdy;

   assign c_rdy      = !c_valid_ff || rsp_tready;
   assign b_rdy      = !b_valid_ff || c_rdy;
   assign a_rdy      = !a_valid_ff || b_rdy;
   assign req_tready = a_rdy;
   assign req_accept = req_tvalid && a_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_rdy) a_valid_ff <= req_tvalid;
         if (b_rdy) b_valid_ff <= a_valid_ff;
         if (c_rdy) c_valid_ff <= b_valid_ff;
      end
   end

   // Stage A: flags and the stamps after this sample
   rsp_flags_type         a_flags_ff;
   logic [TIME_WIDTH-1:0] a_start_ff;
   logic [TIME_WIDTH-1:0] a_stop_ff;

   always_ff @(posedge clock) begin
      if (a_rdy) begin
         a_flags_ff.relay_on          <= pump_running_in;
         a_flags_ff.auto_enabled      <= auto_mode_in;
         a_flags_ff.short_cycle_fault <= fault_in;
         a_flags_ff.backlight_on      <= backlight_in;
         a_flags_ff.auto_event        <= aev;
         a_flags_ff.command_event     <= cev;
         a_flags_ff.last_run_valid    <= run_valid;
         a_start_ff                   <= start_stamp_in;
         a_stop_ff                    <= stop_stamp_in;
      end
   end

   // Stage B: run length, saturation check, dividend for /1000
   logic [TIME_WIDTH-1:0] run_ms;
   logic [63:0]           run_ms_w;
   logic                  run_sat;
   rsp_flags_type         b_flags_ff;
   logic                  b_sat_ff;
   logic [DIVQ_W-1:0]     b_div_ff;

   assign run_ms   = a_stop_ff - a_start_ff;
   assign run_ms_w = 64'(run_ms);
   assign run_sat  = run_ms_w >= SAT_LIMIT;

   always_ff @(posedge clock) begin
      if (b_rdy) begin
         b_flags_ff <= a_flags_ff;
         b_sat_ff   <= a_flags_ff.last_run_valid && run_sat;
         b_div_ff   <= (a_flags_ff.last_run_valid && !run_sat) ?
                       run_ms_w[DIVQ_W+2:3] : '0;
      end
   end

   // Stage C: reciprocal multiply, then saturate into the output register
   logic [PROD_W-1:0] prod;
   rsp_flags_type     c_flags_ff;
   logic [SEC_W-1:0]  c_secs_ff;

   assign prod = PROD_W'(b_div_ff) * PROD_W'(RECIP_125);

   always_ff @(posedge clock) begin
      if (c_rdy) begin
         c_flags_ff <= b_flags_ff;
         c_secs_ff  <= b_sat_ff ? SEC_MAX : prod[RECIP_SHIFT+SEC_W-1:RECIP_SHIFT];
      end
   end

   // Response beat
   assign rsp_tvalid = c_valid_ff;
   assign rsp_tdata  = {7'b0,
                        c_flags_ff.last_run_valid,
                        c_secs_ff,
                        c_flags_ff.command_event,
                        c_flags_ff.auto_event,
                        c_flags_ff.backlight_on,
                        c_flags_ff.short_cycle_fault,
                        c_flags_ff.auto_enabled,
                        c_flags_ff.relay_on};

   // Checks
   a_fault_clear_by_restart: assert property (@(posedge clock) disable iff (reset)
      $fell(fault_ff) |-> $past(req_accept && req_func == FUNC_RESTART))
      else $error("fault cleared without restart");

   a_auto_run_implies_running: assert property (@(posedge clock) disable iff (reset)
      run_from_auto_ff |-> pump_running_ff)
      else $error("auto run flag set with pump stopped");

   a_invalid_run_zero_secs: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[32]) |-> (rsp_tdata[31:9] == '0))
      else $error("run seconds nonzero without a valid run");

   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !c_valid_ff |-> req_tready)
      else $error("request stalled with empty output stage");

endmodule
`default_nettype wire

### tb/plcl_status_checker.sv
// Checker for the pump level controller: predicts every response beat and compares it.
module plcl_status_checker
   import plcl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // now_ms[31:0], low_level_up, high_level_up
   input  wire logic [REQ_USER_W-1:0] req_tuser,  // func[2:0]
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,  // relay_on, auto_enabled, short_cycle_fault,
                                                  // backlight_on, auto_event[1:0],
                                                  // command_event[2:0],
                                                  // last_run_seconds[22:0], last_run_valid
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pending,
   output int                         checked
);

   // Response fields, MSB first so the struct maps onto rsp_tdata[32:0]
   typedef struct packed {
      logic        last_run_valid;
      logic [22:0] last_run_seconds;
      logic [2:0]  command_event;
      logic [1:0]  auto_event;
      logic        backlight_on;
      logic        short_cycle_fault;
      logic        auto_enabled;
      logic        relay_on;
   } pump_status_type;

   pump_status_type status_q[$];
   int              errs;
   int              checks;

   // Shadow lockout registers
   logic [31:0] cfg_auto_lk;
   logic [31:0] cfg_man_lk;

   // Shadow pump state
   logic [31:0] start_ms;
   logic [31:0] stop_ms;
   bit          has_started;
   bit          has_stopped;
   bit          running;
   bit          auto_run;
   bit          fault;
   bit          auto_on;
   bit          light;

   task automatic clear_pump();
      start_ms    = '0;
      stop_ms     = '0;
      has_started = 1'b0;
      has_stopped = 1'b0;
      running     = 1'b0;
      auto_run    = 1'b0;
      fault       = 1'b0;
      auto_on     = 1'b1;
      light       = 1'b0;
   endtask

   task automatic start_pump(input logic [31:0] t, input bit from_auto);
      running     = 1'b1;
      auto_run    = from_auto;
      start_ms    = t;
      has_started = 1'b1;
   endtask

   task automatic stop_pump(input logic [31:0] t);
      running     = 1'b0;
      auto_run    = 1'b0;
      stop_ms     = t;
      has_stopped = 1'b1;
   endtask

   // One sample: automatic step, then high-level stop, then the command
   task automatic step_pump(input logic [2:0] cmd, input logic [31:0] now,
                            input bit low_up, input bit high_up, output pump_status_type st);
      logic [31:0] since_stop;
      logic [31:0] since_start;
      logic [31:0] secs;
      logic [1:0]  aev;
      logic [2:0]  cev;
      bit          run_ok;
      aev = AEV_NONE;
      cev = CEV_NONE;
      if (!fault && !low_up) begin
         since_stop = now - stop_ms;
         if ((!has_stopped || since_stop >= cfg_auto_lk) && auto_on) begin
            start_pump(now, 1'b1);
            aev = AEV_START;
         end else if (has_stopped && since_stop <= cfg_auto_lk) begin
            fault = 1'b1;
            aev   = AEV_FAULT;
         end
      end
      if (high_up && running && auto_on && (auto_run || cmd == FUNC_SENSE)) begin
         stop_pump(now);
         aev = AEV_STOP;
      end
      case (cmd)
         FUNC_MANUAL_ON: begin
            since_start = now - start_ms;
            if (!has_started || since_start > cfg_man_lk) begin
               start_pump(now, 1'b0);
               cev = CEV_START;
            end else if (!running && since_start < cfg_man_lk) begin
               cev = CEV_REFUSED;
            end
         end
         FUNC_MANUAL_OFF: begin
            if (running) begin
               stop_pump(now);
               cev = CEV_STOP;
            end
         end
         FUNC_AUTO_OFF: auto_on = 1'b0;
         FUNC_AUTO_ON:  auto_on = 1'b1;
         FUNC_BL_OFF:   light = 1'b0;
         FUNC_BL_ON:    light = 1'b1;
         FUNC_RESTART: begin
            clear_pump();
            cev = CEV_RESTART;
         end
         default: ;
      endcase
      // last run length, saturated to the seconds field
      run_ok = has_started && has_stopped && (stop_ms > start_ms);
      secs   = run_ok ? (stop_ms - start_ms) / MS_PER_SEC : 32'd0;
      if (secs > 32'(SEC_MAX)) secs = 32'(SEC_MAX);
      st.relay_on          = running;
      st.auto_enabled      = auto_on;
      st.short_cycle_fault = fault;
      st.backlight_on      = light;
      st.auto_event        = aev;
      st.command_event     = cev;
      st.last_run_seconds  = secs[SEC_W-1:0];
      st.last_run_valid    = run_ok;
   endtask

   task automatic compare_field(input string name, input int unsigned want_v,
                                input int unsigned got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         errs++;
      end
   endtask

   // Track beats: compare responses first, then predict the new request
   always @(posedge clock) begin
      pump_status_type want;
      pump_status_type got;
      if (reset) begin
         cfg_auto_lk = AUTO_LOCKOUT_RST;
         cfg_man_lk  = MANUAL_LOCKOUT_RST;
         clear_pump();
         status_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = pump_status_type'(rsp_tdata[32:0]);
            if (status_q.size() == 0) begin
               $error("response beat with no request outstanding: %h", rsp_tdata);
               errs++;
            end else begin
               want = status_q.pop_front();
               compare_field("relay_on", want.relay_on, got.relay_on);
               compare_field("auto_enabled", want.auto_enabled, got.auto_enabled);
               compare_field("short_cycle_fault", want.short_cycle_fault,
                             got.short_cycle_fault);
               compare_field("backlight_on", want.backlight_on, got.backlight_on);
               compare_field("auto_event", want.auto_event, got.auto_event);
               compare_field("command_event", want.command_event, got.command_event);
               compare_field("last_run_seconds", want.last_run_seconds,
                             got.last_run_seconds);
               compare_field("last_run_valid", want.last_run_valid, got.last_run_valid);
               checks++;
            end
         end
         if (csr_we) begin
            if (csr_addr == CSR_AUTO_LOCKOUT) cfg_auto_lk = csr_wdata;
            else if (csr_addr == CSR_MANUAL_LOCKOUT) cfg_man_lk = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            step_pump(req_tuser[2:0], req_tdata[31:0], req_tdata[32], req_tdata[33], want);
            status_q.push_back(want);
         end
      end
      fail_count <= errs;
      pending    <= status_q.size();
      checked    <= checks;
   end

endmodule

### tb/tb_pump_level_controller_lockout_core.sv
// Testbench top for the pump level controller: clock, reset, stimulus, watchdog and verdict.
module tb_pump_level_controller_lockout_core;
   import plcl_pkg::*;

   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int WATCHDOG_LIMIT  = 2000;

   bit                  clock;
   bit                  reset = 1'b1;
   bit                  req_tvalid;
   logic                req_tready;
   bit [REQ_DATA_W-1:0] req_tdata;  // now_ms[31:0], low_level_up, high_level_up
   bit [REQ_USER_W-1:0] req_tuser;  // func[2:0]
   logic                rsp_tvalid;
   bit                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // relay_on, auto_enabled, short_cycle_fault,
                                      // backlight_on, auto_event[1:0],
                                      // command_event[2:0],
                                      // last_run_seconds[22:0], last_run_valid
   bit                  csr_we;
   bit [CSR_ADDR_W-1:0] csr_addr;
   bit [CSR_DATA_W-1:0] csr_wdata;

   int          fail_count;
   int          pending;
   int          checked;
   int          sent;
   int          idle_cycles;
   int          stall_left;
   bit          quiet;
   bit          rsp_stalls_on = 1'b1;
   logic [31:0] lk_auto = AUTO_LOCKOUT_RST;
   logic [31:0] lk_manual = MANUAL_LOCKOUT_RST;

   pump_level_controller_lockout_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   plcl_status_checker status_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Gap length: mostly short, now and then long
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Next timestamp: near a lockout boundary, repeated, a step of up to twice a lockout plus 16, or a random jump
   function automatic logic [31:0] next_stamp(input logic [31:0] t);
      int unsigned r;
      logic [31:0] lk;
      r  = $urandom_range(0, 99);
      lk = $urandom_range(0, 1) ? lk_auto : lk_manual;
      if (r < 8) return $urandom();
      if (r < 24) return t + lk + $urandom_range(0, 2) - 32'd1;
      if (r < 30) return t;
      return t + $urandom_range(0, (lk > 32'h7FFF_FFF0) ? 32'hFFFF_FFFF : lk * 2 + 16);
   endfunction

   // Drive one request beat and wait for it to be taken
   task automatic send_item(input logic [2:0] fn, input logic [31:0] t,
                            input bit low_up, input bit high_up);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {6'b0, high_up, low_up, t};
      do @(posedge clock); while (!req_tready);
      sent++;
      gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain all outstanding responses, then let the pipeline settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_lockouts(input logic [31:0] auto_ms, input logic [31:0] man_ms);
      wait_idle();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_AUTO_LOCKOUT;
      csr_wdata <= auto_ms;
      @(posedge clock);
      csr_addr  <= CSR_MANUAL_LOCKOUT;
      csr_wdata <= man_ms;
      @(posedge clock);
      csr_we    <= 1'b0;
      lk_auto   = auto_ms;
      lk_manual = man_ms;
   endtask

   // Response side back-pressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 99) < 20) begin
         stall_left <= pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles, %0d responses outstanding",
                  idle_cycles, pending);
         $display("pump_level_controller_lockout_core verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int          ph;
      int          i;
      int unsigned r;
      logic [31:0] t;
      logic [2:0]  fn;
      bit          lo;
      bit          hi;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: restart, longest run, fault, manual lockout edges
      send_item(FUNC_RESTART,    32'd0,          1'b1, 1'b0);
      send_item(FUNC_MANUAL_ON,  32'd0,          1'b1, 1'b0);
      send_item(FUNC_MANUAL_OFF, 32'hFFFF_FFFF,  1'b1, 1'b0);
      send_item(FUNC_SENSE,      32'hFFFF_FFFF,  1'b0, 1'b0);  // fault right after stop
      send_item(FUNC_MANUAL_ON,  32'hFFFF_FFFF,  1'b1, 1'b0);  // manual start while faulted
      send_item(FUNC_MANUAL_ON,  32'hFFFF_FFFF,  1'b1, 1'b0);  // running, inside lockout
      send_item(FUNC_MANUAL_OFF, 32'd0,          1'b1, 1'b0);
      send_item(FUNC_MANUAL_ON,  32'd299999,     1'b1, 1'b0);  // exactly on the lockout
      send_item(FUNC_MANUAL_ON,  32'd1000,       1'b1, 1'b0);  // refused
      send_item(FUNC_MANUAL_OFF, 32'd1000,       1'b1, 1'b0);  // stop while stopped
      send_item(FUNC_BL_ON,      32'd1000,       1'b1, 1'b0);
      send_item(FUNC_BL_OFF,     32'd1000,       1'b1, 1'b0);
      // Auto lockout edges and start plus stop in one beat
      send_item(FUNC_RESTART,    32'd5000,       1'b1, 1'b0);
      send_item(FUNC_SENSE,      32'd6000,       1'b0, 1'b1);
      send_item(FUNC_SENSE,      32'd3605999,    1'b0, 1'b0);  // one ms short of lockout
      send_item(FUNC_RESTART,    32'd3605999,    1'b1, 1'b0);
      send_item(FUNC_SENSE,      32'd10000,      1'b0, 1'b1);
      send_item(FUNC_SENSE,      32'd3610000,    1'b0, 1'b0);  // lockout exactly reached
      send_item(FUNC_SENSE,      32'd3611000,    1'b0, 1'b0);  // repeated auto start
      send_item(FUNC_AUTO_OFF,   32'd3612000,    1'b1, 1'b1);
      send_item(FUNC_SENSE,      32'd3613000,    1'b0, 1'b0);  // fault with auto off
      send_item(FUNC_AUTO_ON,    32'd3614000,    1'b1, 1'b0);
      // Full tank stops a manual run only on a sense beat
      send_item(FUNC_RESTART,    32'd20000,      1'b1, 1'b0);
      send_item(FUNC_MANUAL_ON,  32'd20000,      1'b1, 1'b1);
      send_item(FUNC_BL_ON,      32'd21000,      1'b1, 1'b1);
      send_item(FUNC_SENSE,      32'd22000,      1'b1, 1'b1);

      // Random phases, one lockout setting each
      t = 32'd22000;
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            1: write_lockouts(32'd0, 32'd0);
            2: write_lockouts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            3: write_lockouts($urandom_range(100, 5000), $urandom_range(10, 1000));
            4: write_lockouts($urandom_range(1000, 100000), $urandom_range(1000, 100000));
            5: write_lockouts($urandom(), $urandom());
            default: ;
         endcase
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % 64 == 0) begin
               quiet = ($urandom_range(0, 3) == 0);
               rsp_stalls_on <= !quiet;
            end
            // switches: low tank, middle, full, or both odd
            r = $urandom_range(0, 99);
            if (r < 30) begin
               lo = 1'b0; hi = 1'b0;
            end else if (r < 60) begin
               lo = 1'b1; hi = 1'b0;
            end else if (r < 90) begin
               lo = 1'b1; hi = 1'b1;
            end else begin
               lo = 1'b0; hi = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 45)      fn = FUNC_SENSE;
            else if (r < 57) fn = FUNC_MANUAL_ON;
            else if (r < 67) fn = FUNC_MANUAL_OFF;
            else if (r < 73) fn = FUNC_AUTO_OFF;
            else if (r < 83) fn = FUNC_AUTO_ON;
            else if (r < 88) fn = FUNC_BL_OFF;
            else if (r < 93) fn = FUNC_BL_ON;
            else if (r < 97) fn = FUNC_SENSE;
            else             fn = FUNC_RESTART;
            t = next_stamp(t);
            send_item(fn, t, lo, hi);
         end
      end

      wait_idle();
      $display("run covered %0d request beats: directed lockout and fault cases, then %0d",
               sent, NUM_PHASES);
      $display("lockout settings with random switches and commands; %0d responses checked",
               checked);
      if (fail_count == 0) begin
         $display("pump_level_controller_lockout_core verification clean");
      end else begin
         $display("pump_level_controller_lockout_core verification failed");
      end
      $finish;
   end

endmodule
